[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/asp_pkg.sv]
`timescale 1ns / 1ps

package asp_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ACC_WIDTH    = 32;
    localparam int STR_WIDTH    = 8;
    // headroom for the half-turn negation and the cordic gain
    localparam int XY_WIDTH     = COORD_WIDTH + 3;
    localparam int IN_DATA_WIDTH  = 3 * COORD_WIDTH + STR_WIDTH;
    localparam int OUT_DATA_WIDTH = ((IN_DATA_WIDTH + 7) / 8) * 8;

    localparam int REG_IDX_WIDTH = 2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_HEADING     = 2'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_WINDOW_LOW  = 2'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_WINDOW_HIGH = 2'd2;

    localparam logic [ANGLE_WIDTH-1:0] HEADING_RESET     = ANGLE_WIDTH'(0);
    localparam logic [ANGLE_WIDTH-1:0] WINDOW_LOW_RESET  = ANGLE_WIDTH'(-6372);
    localparam logic [ANGLE_WIDTH-1:0] WINDOW_HIGH_RESET = ANGLE_WIDTH'(6372);

    localparam logic [ACC_WIDTH-1:0] HALF_TURN = ACC_WIDTH'(1) << (ACC_WIDTH - 1);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ACC_WIDTH-1:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // point payload and flags that ride along the pipeline
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [STR_WIDTH-1:0]          strength;
        logic                          cloud_end;
        logic                          origin;
    } t_point;

endpackage

[src/azimuth_sector_point_filter_core.sv]
`timescale 1ns / 1ps

// Azimuth field-of-view filter for a lidar point stream. Each point gets its
// azimuth atan2(y, x) from a 16-step pipelined CORDIC as a 16-bit binary
// angle (65536 is a full turn, the origin gives 0); the heading is
// subtracted modulo a turn and the point is flagged inside (tuser) when the
// signed difference lies in [window_low, window_high]. One point is taken
// every clock unless the output is blocked. The pipeline has one entry
// stage, one stage per CORDIC step, one rounding and heading stage and the
// compare/output register. The whole pipeline holds while a result waits at
// the output. Write the heading and window registers only while the pipeline is empty.
module azimuth_sector_point_filter_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [asp_pkg::REG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [asp_pkg::ANGLE_WIDTH-1:0]       i_cfg_data,
    // input points
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pos_x, pos_y, pos_z, strength
    input  logic [asp_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,
    // cloud_end
    input  logic                                  s_axis_tlast,
    // results
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_x, out_y, out_z, out_strength
    output logic [asp_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,
    // inside_res
    output logic                                  m_axis_tuser,
    // out_end
    output logic                                  m_axis_tlast
);
    import asp_pkg::*;
    `include "assert_macros.svh"

    localparam logic [ACC_WIDTH-1:0] ROUND_HALF =
        ACC_WIDTH'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH);

    logic [ANGLE_WIDTH-1:0] r_heading;
    logic [ANGLE_WIDTH-1:0] r_window_low;
    logic [ANGLE_WIDTH-1:0] r_window_high;

    logic w_en;

    // entry stage
    t_point                     n_pre_point;
    logic signed [XY_WIDTH-1:0] n_pre_x;
    logic signed [XY_WIDTH-1:0] n_pre_y;
    logic [ACC_WIDTH-1:0]       n_pre_acc;
    logic                       r_pre_valid;
    t_point                     r_pre_point;
    logic signed [XY_WIDTH-1:0] r_pre_x;
    logic signed [XY_WIDTH-1:0] r_pre_y;
    logic [ACC_WIDTH-1:0]       r_pre_acc;

    logic                       w_cor_valid;
    logic [ACC_WIDTH-1:0]       w_cor_acc;
    t_point                     w_cor_point;

    // rounding and heading stage
    logic [ACC_WIDTH-1:0]       w_rounded;
    logic [ANGLE_WIDTH-1:0]     n_diff;
    logic                       r_round_valid;
    t_point                     r_round_point;
    logic [ANGLE_WIDTH-1:0]     r_diff;

    // output register
    logic                       n_inside;
    logic                       r_out_valid;
    t_point                     r_out_point;
    logic                       r_out_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading     <= HEADING_RESET;
            r_window_low  <= WINDOW_LOW_RESET;
            r_window_high <= WINDOW_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEADING:     r_heading     <= i_cfg_data;
                REG_WINDOW_LOW:  r_window_low  <= i_cfg_data;
                REG_WINDOW_HIGH: r_window_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        n_pre_point.pos_x     = s_axis_tdata[COORD_WIDTH-1:0];
        n_pre_point.pos_y     = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        n_pre_point.pos_z     = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
        n_pre_point.strength  = s_axis_tdata[IN_DATA_WIDTH-1:3*COORD_WIDTH];
        n_pre_point.cloud_end = s_axis_tlast;
        n_pre_point.origin    = (n_pre_point.pos_x == '0) && (n_pre_point.pos_y == '0);
        n_pre_x = XY_WIDTH'(n_pre_point.pos_x);
        n_pre_y = XY_WIDTH'(n_pre_point.pos_y);
        n_pre_acc = '0;
        // left half plane: turn by half a turn first
        if (n_pre_point.pos_x[COORD_WIDTH-1]) begin
            n_pre_x   = -n_pre_x;
            n_pre_y   = -n_pre_y;
            n_pre_acc = HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid   <= 1'b0;
            r_round_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (w_en) begin
            r_pre_valid   <= s_axis_tvalid;
            r_round_valid <= w_cor_valid;
            r_out_valid   <= r_round_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre_point   <= n_pre_point;
            r_pre_x       <= n_pre_x;
            r_pre_y       <= n_pre_y;
            r_pre_acc     <= n_pre_acc;
            r_round_point <= w_cor_point;
            r_diff        <= n_diff;
            r_out_point   <= r_round_point;
            r_out_inside  <= n_inside;
        end
    end

    asp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_pre_valid),
        .i_x     (r_pre_x),
        .i_y     (r_pre_y),
        .i_acc   (r_pre_acc),
        .i_point (r_pre_point),
        .o_valid (w_cor_valid),
        .o_acc   (w_cor_acc),
        .o_point (w_cor_point)
    );

    // round half up to the angle width, wrap modulo a turn, then take off the heading
    assign w_rounded = w_cor_acc + ROUND_HALF;
    assign n_diff = w_cor_point.origin
                  ? (ANGLE_WIDTH'(0) - r_heading)
                  : (w_rounded[ACC_WIDTH-1 -: ANGLE_WIDTH] - r_heading);

    assign n_inside = ($signed(r_diff) >= $signed(r_window_low))
                   && ($signed(r_diff) <= $signed(r_window_high));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_WIDTH'({r_out_point.strength, r_out_point.pos_z,
                                            r_out_point.pos_y, r_out_point.pos_x});
    assign m_axis_tuser  = r_out_inside;
    assign m_axis_tlast  = r_out_point.cloud_end;

    `ASP_ASSERT(a_hold_when_blocked, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output blocked")
    `ASP_ASSERT(a_round_reaches_out, i_clk, i_rst_n,
        r_round_valid && w_en |=> m_axis_tvalid, "result lost before output register")
    `ASP_ASSERT(a_stall_freezes_entry, i_clk, i_rst_n,
        !w_en |=> $stable(r_pre_valid) && $stable(r_round_valid), "pipeline moved during stall")
    `ASP_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> !m_axis_tvalid && !r_pre_valid, "pipeline not empty after reset")

endmodule

[src/asp_cordic.sv]
`timescale 1ns / 1ps

module asp_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [asp_pkg::XY_WIDTH-1:0]  i_x,
    input  logic signed [asp_pkg::XY_WIDTH-1:0]  i_y,
    input  logic [asp_pkg::ACC_WIDTH-1:0]        i_acc,
    input  asp_pkg::t_point                      i_point,
    output logic                                 o_valid,
    output logic [asp_pkg::ACC_WIDTH-1:0]        o_acc,
    output asp_pkg::t_point                      o_point
);
    import asp_pkg::*;

    logic                       r_v     [CORDIC_STEPS];
    logic signed [XY_WIDTH-1:0] r_x     [CORDIC_STEPS];
    logic signed [XY_WIDTH-1:0] r_y     [CORDIC_STEPS];
    logic [ACC_WIDTH-1:0]       r_acc   [CORDIC_STEPS];
    t_point                     r_point [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic                       w_v;
        logic signed [XY_WIDTH-1:0] w_x;
        logic signed [XY_WIDTH-1:0] w_y;
        logic [ACC_WIDTH-1:0]       w_acc;
        t_point                     w_point;
        logic signed [XY_WIDTH-1:0] n_x;
        logic signed [XY_WIDTH-1:0] n_y;
        logic [ACC_WIDTH-1:0]       n_acc;

        if (k == 0) begin : g_first
            assign w_v     = i_valid;
            assign w_x     = i_x;
            assign w_y     = i_y;
            assign w_acc   = i_acc;
            assign w_point = i_point;
        end else begin : g_next
            assign w_v     = r_v[k-1];
            assign w_x     = r_x[k-1];
            assign w_y     = r_y[k-1];
            assign w_acc   = r_acc[k-1];
            assign w_point = r_point[k-1];
        end

        // rotate towards the x axis, direction from the sign of y
        always_comb begin
            if (!w_y[XY_WIDTH-1]) begin
                n_x   = w_x + (w_y >>> k);
                n_y   = w_y - (w_x >>> k);
                n_acc = w_acc + ATAN_TURNS[k];
            end else begin
                n_x   = w_x - (w_y >>> k);
                n_y   = w_y + (w_x >>> k);
                n_acc = w_acc - ATAN_TURNS[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]     <= n_x;
                r_y[k]     <= n_y;
                r_acc[k]   <= n_acc;
                r_point[k] <= w_point;
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_acc   = r_acc[CORDIC_STEPS-1];
    assign o_point = r_point[CORDIC_STEPS-1];

endmodule
